[sv/avcc_to_annexb_converter_macros.svh]
// Assertion macros used by the converter's parser RTL.
`ifndef AVCC_TO_ANNEXB_CONVERTER_MACROS_SVH
`define AVCC_TO_ANNEXB_CONVERTER_MACROS_SVH

`ifndef ASSERT_OFF
`define AVAB_ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AVAB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AVAB_ASSERT_RST(label, clk, rst, prop, msg)
`define AVAB_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[sv/avab_pkg.sv]
package avab_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       packet_error;
    logic       idr_found;
  } out_item_t;

  localparam logic [4:0] NAL_TYPE_IDR = 5'd5;
  localparam logic [1:0] HDR_LAST     = 2'd3;

  localparam logic [7:0] ANNEXB_PREFIX [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

endpackage

[sv/avcc_to_annexb_converter.sv]
// AVCC to Annex B converter: one byte item per clock in and out when not stalled, through
// an input register, then the parser state update feeding a result register. Each 4-byte
// big-endian NAL length becomes 00 00 00 01, payload bytes pass unchanged, and on the last byte
// of a packet packet_error and idr_found are reported. The remaining-length counter is 32 bits;
// the block takes an item every cycle in which its input register is empty or being drained,
// and that register drains when the result register is empty or being drained.
module avcc_to_annexb_converter
  import avab_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      mid_valid;
  logic      mid_ready;
  in_item_t  mid_data;
  out_item_t result;

  avab_stage #(.payload_t(in_item_t)) u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_data  (mid_data)
  );

  avab_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (mid_valid && mid_ready),
    .item    (mid_data),
    .result  (result)
  );

  avab_stage #(.payload_t(out_item_t)) u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .up_data  (result),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

endmodule

[sv/avab_stage.sv]
module avab_stage #(
  parameter type payload_t = logic [7:0]
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  output logic     up_ready,
  input  payload_t up_data,
  output logic     dn_valid,
  input  logic     dn_ready,
  output payload_t dn_data
);

  logic     valid;
  payload_t data;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data <= up_data;
    end
  end

endmodule

[sv/avab_parser.sv]
`include "avcc_to_annexb_converter_macros.svh"

module avab_parser
  import avab_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  in_item_t  item,
  output out_item_t result
);

  logic [1:0]  hdr_count;
  logic [31:0] nal_remaining;
  logic [23:0] length_accum;
  logic        at_nal_start;
  logic        idr_seen;

  logic [1:0]  hdr_count_next;
  logic [31:0] nal_remaining_next;
  logic [23:0] length_accum_next;
  logic        at_nal_start_next;
  logic        idr_seen_next;
  logic [31:0] full_length;
  logic        error;

  assign full_length = {length_accum, item.in_byte};

  always_comb begin
    hdr_count_next     = hdr_count;
    nal_remaining_next = nal_remaining;
    length_accum_next  = length_accum;
    at_nal_start_next  = at_nal_start;
    idr_seen_next      = idr_seen;
    result.out_byte    = item.in_byte;

    if (nal_remaining == 32'd0) begin
      result.out_byte   = ANNEXB_PREFIX[hdr_count];
      length_accum_next = {length_accum[15:0], item.in_byte};
      hdr_count_next    = hdr_count + 2'd1;
      if (hdr_count == HDR_LAST) begin
        nal_remaining_next = full_length;
        at_nal_start_next  = (full_length != 32'd0);
        length_accum_next  = '0;
        hdr_count_next     = '0;
      end
    end else begin
      if (at_nal_start && (item.in_byte[4:0] == NAL_TYPE_IDR)) begin
        idr_seen_next = 1'b1;
      end
      at_nal_start_next  = 1'b0;
      nal_remaining_next = nal_remaining - 32'd1;
    end

    error = (hdr_count_next != 2'd0) || (nal_remaining_next != 32'd0);

    result.out_last     = item.in_last;
    result.packet_error = item.in_last && error;
    result.idr_found    = item.in_last && idr_seen_next && !error;

    if (item.in_last) begin
      hdr_count_next     = '0;
      nal_remaining_next = '0;
      length_accum_next  = '0;
      at_nal_start_next  = 1'b0;
      idr_seen_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_count     <= '0;
      nal_remaining <= '0;
      length_accum  <= '0;
      at_nal_start  <= 1'b0;
      idr_seen      <= 1'b0;
    end else if (advance) begin
      hdr_count     <= hdr_count_next;
      nal_remaining <= nal_remaining_next;
      length_accum  <= length_accum_next;
      at_nal_start  <= at_nal_start_next;
      idr_seen      <= idr_seen_next;
    end
  end

  `AVAB_ASSERT_ALWAYS(a_start_has_payload, clk,
    at_nal_start |-> (nal_remaining != 32'd0), "NAL header pending with no payload left")
  `AVAB_ASSERT_ALWAYS(a_header_excludes_payload, clk,
    (hdr_count != 2'd0) |-> (nal_remaining == 32'd0), "length field and payload active together")
  `AVAB_ASSERT_RST(a_clear_after_last, clk, rst,
    (advance && item.in_last) |=> ((hdr_count == 2'd0) && (nal_remaining == 32'd0)
      && !idr_seen && !at_nal_start), "packet state not cleared after last item")
  `AVAB_ASSERT_RST(a_idr_needs_clean_last, clk, rst,
    (advance && result.idr_found) |-> (result.out_last && !result.packet_error),
    "IDR flag on a non-last or failed packet")

endmodule

[sim/tb_avcc_to_annexb_converter.sv]
module tb_avcc_to_annexb_converter
  import avab_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t [$];

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  avcc_to_annexb_converter u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // converter shadow state
  logic [2:0]  hdr_count  = '0;
  logic [31:0] nal_left   = '0;
  logic [31:0] len_accum  = '0;
  logic        nal_head   = 1'b0;
  logic        idr_in_pkt = 1'b0;

  out_item_t expected_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned n_errors      = 0;
  int unsigned n_checked     = 0;
  int unsigned n_packets     = 0;
  int unsigned n_idr_pkts    = 0;
  int unsigned n_bad_pkts    = 0;

  function automatic out_item_t convert_byte(in_item_t it);
    out_item_t r;
    r = '0;
    if (nal_left == 32'd0) begin
      r.out_byte = ANNEXB_PREFIX[hdr_count[1:0]];
      len_accum  = {len_accum[23:0], it.in_byte};
      hdr_count  = hdr_count + 3'd1;
      if (hdr_count == 3'd4) begin
        nal_left  = len_accum;
        nal_head  = (len_accum != 32'd0);
        len_accum = '0;
        hdr_count = '0;
      end
    end else begin
      r.out_byte = it.in_byte;
      if (nal_head) begin
        if (it.in_byte[4:0] == NAL_TYPE_IDR) idr_in_pkt = 1'b1;
        nal_head = 1'b0;
      end
      nal_left = nal_left - 32'd1;
    end
    r.out_last = it.in_last;
    if (it.in_last) begin
      r.packet_error = (hdr_count != 3'd0) || (nal_left != 32'd0);
      r.idr_found    = idr_in_pkt && !r.packet_error;
      hdr_count      = '0;
      nal_left       = '0;
      len_accum      = '0;
      nal_head       = 1'b0;
      idr_in_pkt     = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 100) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected item byte=%02h last=%0b",
                                got.out_byte, got.out_last));
      return;
    end
    want = expected_q.pop_front();
    n_checked++;
    if (got.out_byte !== want.out_byte)
      report_mismatch($sformatf("out_byte got %02h want %02h", got.out_byte, want.out_byte));
    if (got.out_last !== want.out_last)
      report_mismatch($sformatf("out_last got %0b want %0b", got.out_last, want.out_last));
    if (got.packet_error !== want.packet_error)
      report_mismatch($sformatf("packet_error got %0b want %0b",
                                got.packet_error, want.packet_error));
    if (got.idr_found !== want.idr_found)
      report_mismatch($sformatf("idr_found got %0b want %0b", got.idr_found, want.idr_found));
    if (want.out_last) begin
      n_packets++;
      if (want.idr_found) n_idr_pkts++;
      if (want.packet_error) n_bad_pkts++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    in_item_t it;
    it.in_byte = b;
    it.in_last = l;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(convert_byte(it));
  endtask

  task automatic send_packet(input byte_q_t pkt);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_packets();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // zero-length NAL, then an IDR whose header has the upper bits set
    send_packet('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hE5});
    // non-IDR header, IDR value later in the payload does not count
    send_packet('{8'h00, 8'h00, 8'h00, 8'h02, 8'h67, 8'h65});
    // truncated inside the length field
    send_packet('{8'h00, 8'h00, 8'h00});
    // maximum length, truncated in the payload with an IDR header
    send_packet('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h05});
    // single-byte packet
    send_packet('{8'h7F});
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned s_pct, input int unsigned r_pct,
                                     input int unsigned n_items);
    byte_q_t     pkt;
    int unsigned sent;
    int unsigned kind;
    int unsigned sel;
    int unsigned n_nal;
    int unsigned cut;
    logic [31:0] len;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_items) begin
      pkt.delete();
      kind  = $urandom_range(99);
      n_nal = $urandom_range(1, 4);
      for (int k = 0; k < n_nal; k++) begin
        sel = $urandom_range(99);
        if (sel < 10) len = 32'd0;
        else if (sel < 96) len = $urandom_range(1, 12);
        else len = $urandom_range(13, 300);
        pkt.push_back(len[31:24]);
        pkt.push_back(len[23:16]);
        pkt.push_back(len[15:8]);
        pkt.push_back(len[7:0]);
        for (int j = 0; j < len; j++) begin
          if (j == 0 && $urandom_range(99) < 30) pkt.push_back({3'($urandom), NAL_TYPE_IDR});
          else pkt.push_back(8'($urandom));
        end
      end
      if (kind < 12) begin
        cut = $urandom_range(1, pkt.size() - 1);
        while (pkt.size() > cut) void'(pkt.pop_back());
      end else if (kind < 20) begin
        pkt.delete();
        repeat ($urandom_range(1, 10)) pkt.push_back(8'($urandom));
      end
      send_packet(pkt);
      sent += pkt.size();
    end
    wait_drained();
  endtask

  initial begin
    #2_000_000;
    $display("** avcc_to_annexb_converter: FAILED **");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_packets();
    test_random_traffic(15, 54, 430);
    test_random_traffic(54, 15, 430);
    test_random_traffic(0, 0, 430);
    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d items never arrived", expected_q.size()));
    $display("Checked %0d output bytes over %0d packets: %0d flagged IDR, %0d truncated",
             n_checked, n_packets, n_idr_pkts, n_bad_pkts);
    $display("Traffic ran with sender-heavy, receiver-heavy and no backpressure profiles");
    if (n_errors == 0) begin
      $display("** avcc_to_annexb_converter: PASSED **");
    end else begin
      $display("** avcc_to_annexb_converter: FAILED **");
    end
    $finish;
  end

endmodule
